// File: hw/rtl/bmhq_pkg.sv
// Shared constants for the binary max-heap queue: default capacity,
// field widths and the status codes reported with every result.
// No dependencies.
package bmhq_pkg;

    localparam int BMHQ_CAPACITY = 128;
    localparam int KEY_W         = 32;
    localparam int COUNT_W       = 8;
    localparam int STATUS_W      = 2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

// File: hw/rtl/bmhq_ram.sv
// Simple dual-port heap storage: one write port, one read port with
// registered read data. No dependencies.
module bmhq_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/binary_max_heap_queue.sv
// Binary max-heap priority queue: insert a key or remove the maximum.
// Depends on bmhq_pkg and bmhq_ram.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  in      | input     | i_valid / o_ready  | i_op, i_key
//  out     | output    | o_valid / i_ready  | o_status, o_top_key, o_count
//
// One transaction at a time. An insert climbs level by level and a removal descends
// level by level; a dropped insert, an ignored removal and the removal of the last
// entry skip the sift. Each level needs a parent read, or two child reads, through
// the single read port of the heap memory, and a compare.
// Reset clears the entry count and the control; the memory needs no clearing.
// A result waits in the output register; a stalled output holds the next
// result inside the block until the register frees up.
module binary_max_heap_queue #(
    parameter int CAPACITY = bmhq_pkg::BMHQ_CAPACITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic signed [bmhq_pkg::KEY_W-1:0] i_key,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bmhq_pkg::STATUS_W-1:0] o_status,
    output logic signed [bmhq_pkg::KEY_W-1:0] o_top_key,
    output logic [bmhq_pkg::COUNT_W-1:0]  o_count
);
    import bmhq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP_RD   = 3'd1;
    localparam logic [2:0] S_UP_CMP  = 3'd2;
    localparam logic [2:0] S_DN_LAST = 3'd3;
    localparam logic [2:0] S_DN_RD   = 3'd4;
    localparam logic [2:0] S_DN_L    = 3'd5;
    localparam logic [2:0] S_DN_R    = 3'd6;
    localparam logic [2:0] S_FIN     = 3'd7;

    logic [2:0]                r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [AW-1:0]             r_pos, n_pos;
    logic signed [KEY_W-1:0]   r_key, n_key;
    logic signed [KEY_W-1:0]   r_lval, n_lval;
    logic signed [KEY_W-1:0]   r_top;
    logic [STATUS_W-1:0]       r_status, n_status;

    logic                      r_out_valid;
    logic [STATUS_W-1:0]       r_out_status;
    logic signed [KEY_W-1:0]   r_out_top;
    logic [CW-1:0]             r_out_cnt;

    logic                      mem_we;
    logic [AW-1:0]             mem_waddr, mem_raddr;
    logic signed [KEY_W-1:0]   mem_wdata;
    logic [KEY_W-1:0]          mem_rdata;
    logic signed [KEY_W-1:0]   rd_key;

    logic                      in_acc;
    logic                      out_load;
    logic [AW-1:0]             pos_m1, parent;
    logic [CW-1:0]             cnt_m1;
    logic [IW-1:0]             idx_l, idx_r, cnt_x;
    logic                      l_ok, r_ok, l_gt, r_gt;
    logic [CW+COUNT_W-1:0]     cnt_ext;

    bmhq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_key   = $signed(mem_rdata);
    assign o_ready  = (r_state == S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign out_load = (r_state == S_FIN) && (!r_out_valid || i_ready);

    // heap index arithmetic
    assign pos_m1 = r_pos - AW'(1);
    assign parent = pos_m1 >> 1;
    assign cnt_m1 = r_count - CW'(1);
    assign idx_l  = {1'b0, r_pos, 1'b1};
    assign idx_r  = idx_l + IW'(1);
    assign cnt_x  = {{(IW-CW){1'b0}}, r_count};
    assign l_ok   = idx_l < cnt_x;
    assign r_ok   = idx_r < cnt_x;
    assign l_gt   = r_lval > r_key;
    assign r_gt   = r_ok && (rd_key > (l_gt ? r_lval : r_key));

    // sift sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_key     = r_key;
        n_lval    = r_lval;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = r_key;
        mem_raddr = parent;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_key    = i_key;
                    n_status = ST_DONE;
                    if (!i_op) begin
                        if (r_count >= CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_FIN;
                        end else begin
                            n_pos   = r_count[AW-1:0];
                            n_count = r_count + CW'(1);
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_FIN;
                        end else begin
                            n_count   = cnt_m1;
                            mem_raddr = cnt_m1[AW-1:0];
                            n_state   = (cnt_m1 == '0) ? S_FIN : S_DN_LAST;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    mem_we  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    mem_raddr = parent;
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (r_key > rd_key) begin
                    // move the parent down and climb
                    mem_wdata = rd_key;
                    n_pos     = parent;
                    n_state   = S_UP_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DN_LAST: begin
                n_key   = rd_key;
                n_pos   = '0;
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                if (!l_ok) begin
                    mem_we  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    mem_raddr = idx_l[AW-1:0];
                    n_state   = S_DN_L;
                end
            end
            S_DN_L: begin
                n_lval    = rd_key;
                mem_raddr = r_ok ? idx_r[AW-1:0] : r_pos;
                n_state   = S_DN_R;
            end
            S_DN_R: begin
                mem_we = 1'b1;
                if (r_gt) begin
                    mem_wdata = rd_key;
                    n_pos     = idx_r[AW-1:0];
                    n_state   = S_DN_RD;
                end else if (l_gt) begin
                    mem_wdata = r_lval;
                    n_pos     = idx_l[AW-1:0];
                    n_state   = S_DN_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working payload; shadow the root entry on every write to it
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_key    <= n_key;
        r_lval   <= n_lval;
        r_status <= n_status;
        if (mem_we && mem_waddr == '0) begin
            r_top <= mem_wdata;
        end
        if (out_load) begin
            r_out_status <= r_status;
            r_out_top    <= (r_count == '0) ? '0 : r_top;
            r_out_cnt    <= r_count;
        end
    end

    assign cnt_ext   = {{COUNT_W{1'b0}}, r_out_cnt};
    assign o_valid   = r_out_valid;
    assign o_status  = r_out_status;
    assign o_top_key = r_out_top;
    assign o_count   = cnt_ext[COUNT_W-1:0];

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_ready)
        else $error("second transaction taken while busy");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (r_out_cnt == CW'(CAPACITY)))
        else $error("full status with room left");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> (r_out_cnt == '0 && o_top_key == '0))
        else $error("empty status with entries held");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_out_cnt == '0) |-> (o_top_key == '0))
        else $error("nonzero top key on empty heap");

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for binary_max_heap_queue: directed and random insert/remove traffic.
// Depends on bmhq_pkg and the binary_max_heap_queue RTL; holds its own heap model in a scoreboard.

typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
} heap_op_e;

typedef struct packed {
    logic [bmhq_pkg::STATUS_W-1:0]     status;
    logic signed [bmhq_pkg::KEY_W-1:0] top_key;
    logic [bmhq_pkg::COUNT_W-1:0]      count;
} heap_result_t;

class heap_scoreboard;
    localparam int DEPTH       = bmhq_pkg::BMHQ_CAPACITY;
    localparam int SHOW_LIMIT  = 10;

    logic signed [bmhq_pkg::KEY_W-1:0] heap_keys [DEPTH];
    int unsigned   n_entries;
    heap_result_t  expected_q [$];
    int unsigned   fail_count;
    int unsigned   result_index;

    function new();
        n_entries    = 0;
        fail_count   = 0;
        result_index = 0;
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    // Apply one accepted input transaction to the heap and queue the result it yields
    function void note_input(heap_op_e op, logic signed [bmhq_pkg::KEY_W-1:0] key);
        heap_result_t                      res;
        int unsigned                       pos;
        int unsigned                       up;
        int unsigned                       best;
        int unsigned                       lc;
        int unsigned                       rc;
        logic signed [bmhq_pkg::KEY_W-1:0] tmp;
        res.status = bmhq_pkg::ST_DONE;
        if (op == OP_INSERT) begin
            if (n_entries >= DEPTH) begin
                res.status = bmhq_pkg::ST_FULL;
            end else begin
                heap_keys[n_entries] = key;
                n_entries++;
                // climb while the parent is strictly smaller
                pos = n_entries - 1;
                while (pos != 0) begin
                    up = (pos - 1) / 2;
                    if (!(heap_keys[pos] > heap_keys[up]))
                        break;
                    tmp             = heap_keys[pos];
                    heap_keys[pos]  = heap_keys[up];
                    heap_keys[up]   = tmp;
                    pos             = up;
                end
            end
        end else begin
            if (n_entries == 0) begin
                res.status = bmhq_pkg::ST_EMPTY;
            end else begin
                n_entries--;
                if (n_entries != 0) begin
                    heap_keys[0] = heap_keys[n_entries];
                    // descend toward the larger child, left wins a tie
                    pos = 0;
                    while (1) begin
                        best = pos;
                        lc   = 2 * pos + 1;
                        rc   = lc + 1;
                        if (lc < n_entries && heap_keys[lc] > heap_keys[best])
                            best = lc;
                        if (rc < n_entries && heap_keys[rc] > heap_keys[best])
                            best = rc;
                        if (best == pos)
                            break;
                        tmp              = heap_keys[pos];
                        heap_keys[pos]   = heap_keys[best];
                        heap_keys[best]  = tmp;
                        pos              = best;
                    end
                end
            end
        end
        res.top_key = (n_entries != 0) ? heap_keys[0] : '0;
        res.count   = n_entries[bmhq_pkg::COUNT_W-1:0];
        expected_q.push_back(res);
    endfunction

    // Compare one accepted output transaction against the oldest prediction
    function void check_result(logic [bmhq_pkg::STATUS_W-1:0] status,
                               logic signed [bmhq_pkg::KEY_W-1:0] top_key,
                               logic [bmhq_pkg::COUNT_W-1:0] count);
        heap_result_t want;
        result_index++;
        if (expected_q.size() == 0) begin
            fail_count++;
            if (fail_count <= SHOW_LIMIT)
                $display("%0t result %0d: unexpected, status %0d top_key %0d count %0d",
                         $realtime, result_index, status, top_key, count);
            return;
        end
        want = expected_q.pop_front();
        if (status !== want.status || top_key !== want.top_key || count !== want.count) begin
            fail_count++;
            if (fail_count <= SHOW_LIMIT) begin
                $write("%0t result %0d: status exp %0d got %0d, ",
                       $realtime, result_index, want.status, status);
                $display("top_key exp %0d got %0d, count exp %0d got %0d",
                         want.top_key, top_key, want.count, count);
            end
        end
    endfunction

    // Count predictions that never got a result
    function void close_out();
        if (expected_q.size() != 0) begin
            fail_count += expected_q.size();
            $display("%0t %0d expected results never arrived", $realtime, expected_q.size());
        end
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CAPACITY      = bmhq_pkg::BMHQ_CAPACITY;
    localparam int unsigned CYCLE_LIMIT   = 800000;
    localparam int          SETTLE_CYCLES = 64;

    logic                              i_clk   = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              i_op    = 1'b0;
    logic signed [bmhq_pkg::KEY_W-1:0] i_key   = '0;
    logic                              i_ready = 1'b0;
    logic                              o_ready;
    logic                              o_valid;
    logic [bmhq_pkg::STATUS_W-1:0]     o_status;
    logic signed [bmhq_pkg::KEY_W-1:0] o_top_key;
    logic [bmhq_pkg::COUNT_W-1:0]      o_count;

    int unsigned    send_idle_pct = 26;
    int unsigned    recv_idle_pct = 78;
    int unsigned    cycle_count   = 0;
    heap_scoreboard sb            = new();

    binary_max_heap_queue #(.CAPACITY(CAPACITY)) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_op      (i_op),
        .i_key     (i_key),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_status  (o_status),
        .o_top_key (o_top_key),
        .o_count   (o_count)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Throttle the output channel
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check every output transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_status, o_top_key, o_count);
    end

    // Mix of full-range, boundary, clustered and moderate keys
    function automatic logic signed [bmhq_pkg::KEY_W-1:0] pick_key();
        case ($urandom_range(9))
            0, 1, 2: return $urandom;
            3: begin
                case ($urandom_range(4))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7fff_ffff;
                    2:       return 32'sd0;
                    3:       return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            4, 5, 6: return int'($urandom_range(16)) - 8;
            default: return int'($urandom_range(2000)) - 1000;
        endcase
    endfunction

    // Drive one input transaction; enter and leave at a falling edge
    task automatic send_item(input heap_op_e op, input logic signed [bmhq_pkg::KEY_W-1:0] key);
        bit accepted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid  = 1'b1;
        i_op     = op;
        i_key    = key;
        accepted = 1'b0;
        while (!accepted) begin
            @(posedge i_clk);
            accepted = o_ready;
        end
        sb.note_input(op, key);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every result is back, then let the block settle
    task automatic drain_wait();
        i_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Segments that fill, drain or churn the heap with random keys
    task automatic run_random(input int unsigned n_items);
        int unsigned done_items;
        int unsigned seg_len;
        int unsigned insert_pct;
        heap_op_e    op;
        done_items = 0;
        seg_len    = 170;
        insert_pct = 92;
        while (done_items < n_items) begin
            if ($urandom_range(99) < insert_pct)
                op = OP_INSERT;
            else
                op = OP_REMOVE;
            send_item(op, pick_key());
            done_items++;
            seg_len--;
            if (seg_len == 0) begin
                case ($urandom_range(2))
                    0:       insert_pct = 92;
                    1:       insert_pct = 8;
                    default: insert_pct = 50;
                endcase
                seg_len = $urandom_range(200, 20);
            end
        end
    endtask

    initial begin
        // Hold reset, then release it
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: empty remove, extreme and equal keys, drain past empty
        send_item(OP_REMOVE, 32'sh7fff_ffff);
        send_item(OP_INSERT, 32'sd0);
        send_item(OP_INSERT, 32'sh8000_0000);
        send_item(OP_INSERT, 32'sh7fff_ffff);
        send_item(OP_INSERT, -32'sd1);
        send_item(OP_INSERT, 32'sd1);
        send_item(OP_INSERT, 32'sh7fff_ffff);
        send_item(OP_INSERT, 32'sd5);
        send_item(OP_INSERT, 32'sd5);
        send_item(OP_INSERT, 32'sd5);
        repeat (10) send_item(OP_REMOVE, pick_key());
        send_item(OP_INSERT, 32'sh8000_0000);
        send_item(OP_REMOVE, 32'sd0);
        send_item(OP_REMOVE, 32'sh8000_0000);

        // Phase 1: sender mostly busy, receiver mostly stalled
        run_random(420);
        drain_wait();

        // Phase 2: roles swapped
        send_idle_pct = 78;
        recv_idle_pct = 26;
        run_random(420);
        drain_wait();

        // Phase 3: full throughput
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(410);
        drain_wait();

        sb.close_out();
        if (sb.fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// File: binary_max_heap_queue.f
hw/rtl/bmhq_pkg.sv
hw/rtl/bmhq_ram.sv
hw/rtl/binary_max_heap_queue.sv
tb/sv/tb.sv
